// ----- sv/rau_pkg.sv -----
// Package with opcodes, widths and shared types of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int OP_W  = 3;
    localparam int NUM_W = 32;
    localparam int DEN_W = 31;
    localparam int WIDE_W = 64;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_NEG = 3'd3;
    localparam logic [OP_W-1:0] OP_RED = 3'd4;
    localparam logic [OP_W-1:0] OP_EQU = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [NUM_W-1:0] a_numerator;
        logic [DEN_W-1:0]        a_denominator;
        logic signed [NUM_W-1:0] b_numerator;
        logic [DEN_W-1:0]        b_denominator;
    } rau_req_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] result_numerator;
        logic [DEN_W-1:0]        result_denominator;
        logic                    equal_flag;
        logic                    overflow_flag;
        logic                    error_flag;
    } rau_rsp_t;
endpackage

// ----- sv/rau_req_if.sv -----
// Request channel interface of the rational arithmetic unit.
`timescale 1ns / 1ps
interface rau_req_if import rau_pkg::*; ();
    logic     valid;
    logic     ready;
    rau_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/rau_rsp_if.sv -----
// Result channel interface of the rational arithmetic unit.
`timescale 1ns / 1ps
interface rau_rsp_if import rau_pkg::*; ();
    logic     valid;
    logic     ready;
    rau_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/rau_divider.sv -----
// Shared 64-bit restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rau_divider import rau_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE_W-1:0] dividend,
    input  logic [WIDE_W-1:0] divisor,
    output logic              done,
    output logic [WIDE_W-1:0] quotient,
    output logic [WIDE_W-1:0] remainder
);
    localparam int CNT_W = $clog2(WIDE_W + 1);

    logic [WIDE_W-1:0] q_reg, q_next;
    logic [WIDE_W-1:0] r_reg, r_next;
    logic [WIDE_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WIDE_W:0]   shifted;
    logic [WIDE_W:0]   diff;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg, q_reg[WIDE_W-1]};
        diff      = shifted - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CNT_W'(WIDE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDE_W])
            begin
                r_next = diff[WIDE_W-1:0];
                q_next = {q_reg[WIDE_W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[WIDE_W-1:0];
                q_next = {q_reg[WIDE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

// ----- sv/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit with its sequencer.
`timescale 1ns / 1ps
// Adds, subtracts, multiplies, negates, reduces or compares fractions and
// returns each result in lowest terms. One request is taken at a time. Each
// 64-bit division runs in the shared restoring divider, and the Euclidean
// GCD needs one division per remainder step plus two for the final quotients,
// with about 92 Euclid steps for the worst operands on 64-bit values; the
// equality test runs two reductions on 32-bit values. The cross products and
// the product of the denominators use one 33x33 signed multiplier in turn. A
// new request is accepted as soon as the previous result has been loaded into
// the output register, even while that result still waits to be taken.
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    rau_req_if.sink   req,
    rau_rsp_if.source rsp
);
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] S_MUL1  = 4'd1;
    localparam logic [ST_W-1:0] S_MUL2  = 4'd2;
    localparam logic [ST_W-1:0] S_MUL3  = 4'd3;
    localparam logic [ST_W-1:0] S_SUM   = 4'd4;
    localparam logic [ST_W-1:0] S_GCD   = 4'd5;
    localparam logic [ST_W-1:0] S_GWAIT = 4'd6;
    localparam logic [ST_W-1:0] S_DIVN  = 4'd7;
    localparam logic [ST_W-1:0] S_WAITN = 4'd8;
    localparam logic [ST_W-1:0] S_WAITD = 4'd9;
    localparam logic [ST_W-1:0] S_DONE  = 4'd10;
    localparam logic [ST_W-1:0] S_OUT   = 4'd11;

    localparam logic [WIDE_W-1:0] LIM = (WIDE_W'(1) << (VALUE_BITS - 1)) - WIDE_W'(1);

    logic [ST_W-1:0]   state_reg, state_next;
    rau_req_t          in_reg, in_next;
    logic [WIDE_W-1:0] p1_reg, p1_next;
    logic [WIDE_W-1:0] mag_reg, mag_next;
    logic [WIDE_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [WIDE_W-1:0] gx_reg, gx_next;
    logic [WIDE_W-1:0] gy_reg, gy_next;
    logic              second_reg, second_next;
    logic              fa_neg_reg, fa_neg_next;
    logic [WIDE_W-1:0] fa_mag_reg, fa_mag_next;
    logic [WIDE_W-1:0] fa_den_reg, fa_den_next;
    rau_rsp_t          res_reg, res_next;
    rau_rsp_t          out_reg, out_next;
    logic              ovalid_reg, ovalid_next;

    logic signed [NUM_W:0]     m_a;
    logic signed [NUM_W:0]     m_b;
    logic signed [2*NUM_W+1:0] m_p;
    logic [WIDE_W-1:0]         sum_w;
    logic                      div_start;
    logic [WIDE_W-1:0]         div_dividend, div_divisor;
    logic                      div_done;
    logic [WIDE_W-1:0]         div_q, div_r;
    logic                      den_err;
    logic [WIDE_W-1:0]         mag_lim;

    rau_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // One shared signed multiplier; operands are selected by the state.
    always_comb
    begin
        m_a = '0;
        m_b = '0;
        unique case (state_reg)
            S_MUL1:
            begin
                m_a = (NUM_W+1)'(in_reg.a_numerator);
                m_b = (in_reg.opcode == OP_MUL) ? (NUM_W+1)'(in_reg.b_numerator)
                                                : $signed({2'b00, in_reg.b_denominator});
            end
            S_MUL2:
            begin
                m_a = (NUM_W+1)'(in_reg.b_numerator);
                m_b = $signed({2'b00, in_reg.a_denominator});
            end
            S_MUL3:
            begin
                m_a = $signed({2'b00, in_reg.a_denominator});
                m_b = $signed({2'b00, in_reg.b_denominator});
            end
            default:
            begin
                m_a = '0;
                m_b = '0;
            end
        endcase
        m_p = m_a * m_b;
    end

    assign sum_w = (in_reg.opcode == OP_SUB) ? p1_reg - mag_reg : p1_reg + mag_reg;

    always_comb
    begin
        state_next   = state_reg;
        in_next      = in_reg;
        p1_next      = p1_reg;
        mag_next     = mag_reg;
        den_next     = den_reg;
        neg_next     = neg_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        second_next  = second_reg;
        fa_neg_next  = fa_neg_reg;
        fa_mag_next  = fa_mag_reg;
        fa_den_next  = fa_den_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        ovalid_next  = ovalid_reg;
        div_start    = 1'b0;
        div_dividend = gx_reg;
        div_divisor  = gy_reg;
        den_err      = 1'b0;
        mag_lim      = neg_reg ? LIM + WIDE_W'(1) : LIM;

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    in_next     = req.data;
                    second_next = 1'b0;
                    state_next  = S_MUL1;
                end
            end
            S_MUL1:
            begin
                den_err = (in_reg.a_denominator == '0) ||
                          ((in_reg.opcode == OP_ADD || in_reg.opcode == OP_SUB ||
                            in_reg.opcode == OP_MUL || in_reg.opcode == OP_EQU) &&
                           in_reg.b_denominator == '0);
                p1_next = WIDE_W'(m_p);
                if (in_reg.opcode > OP_EQU)
                begin
                    res_next   = '{default: '0};
                    res_next.result_denominator = DEN_W'(1);
                    state_next = S_OUT;
                end
                else if (den_err)
                begin
                    res_next   = '{default: '0};
                    res_next.result_denominator = DEN_W'(1);
                    res_next.error_flag = 1'b1;
                    state_next = S_OUT;
                end
                else if (in_reg.opcode == OP_NEG || in_reg.opcode == OP_RED ||
                         in_reg.opcode == OP_EQU)
                begin
                    // Load a lone fraction as a signed 64-bit numerator.
                    p1_next = WIDE_W'(in_reg.a_numerator);
                    if (in_reg.opcode == OP_NEG)
                    begin
                        p1_next = WIDE_W'(0) - WIDE_W'(in_reg.a_numerator);
                    end
                    den_next   = WIDE_W'(in_reg.a_denominator);
                    state_next = S_SUM;
                end
                else if (in_reg.opcode == OP_MUL)
                begin
                    mag_next   = '0;
                    state_next = S_MUL3;
                end
                else
                begin
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                mag_next   = WIDE_W'(m_p);
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                den_next   = WIDE_W'(m_p);
                p1_next    = sum_w;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // p1 holds the signed numerator, den the denominator.
                neg_next = p1_reg[WIDE_W-1];
                mag_next = p1_reg[WIDE_W-1] ? WIDE_W'(0) - p1_reg : p1_reg;
                gx_next  = p1_reg[WIDE_W-1] ? WIDE_W'(0) - p1_reg : p1_reg;
                gy_next  = den_reg;
                if (p1_reg == '0)
                begin
                    neg_next   = 1'b0;
                    den_next   = WIDE_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (gy_reg == '0)
                begin
                    div_start    = 1'b1;
                    div_dividend = mag_reg;
                    div_divisor  = gx_reg;
                    state_next   = S_WAITN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_GWAIT;
                end
            end
            S_GWAIT:
            begin
                if (div_done)
                begin
                    gx_next    = gy_reg;
                    gy_next    = div_r;
                    state_next = S_GCD;
                end
            end
            S_WAITN:
            begin
                if (div_done)
                begin
                    mag_next     = div_q;
                    div_start    = 1'b1;
                    div_dividend = den_reg;
                    div_divisor  = gx_reg;
                    state_next   = S_WAITD;
                end
            end
            S_WAITD:
            begin
                if (div_done)
                begin
                    den_next   = div_q;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (in_reg.opcode == OP_EQU)
                begin
                    if (!second_reg)
                    begin
                        fa_neg_next = neg_reg;
                        fa_mag_next = mag_reg;
                        fa_den_next = den_reg;
                        second_next = 1'b1;
                        p1_next     = WIDE_W'(in_reg.b_numerator);
                        den_next    = WIDE_W'(in_reg.b_denominator);
                        state_next  = S_SUM;
                    end
                    else
                    begin
                        res_next = '{default: '0};
                        res_next.result_denominator = DEN_W'(1);
                        res_next.equal_flag = (fa_neg_reg == neg_reg) &&
                                              (fa_mag_reg == mag_reg) &&
                                              (fa_den_reg == den_reg);
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    res_next = '{default: '0};
                    if (den_reg > LIM || mag_reg > mag_lim)
                    begin
                        res_next.result_denominator = DEN_W'(1);
                        res_next.overflow_flag = 1'b1;
                    end
                    else
                    begin
                        res_next.result_numerator = neg_reg
                            ? NUM_W'(WIDE_W'(0) - mag_reg) : NUM_W'(mag_reg);
                        res_next.result_denominator = DEN_W'(den_reg);
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Wait until the output register is free, then load it.
                if (!ovalid_reg || rsp.ready)
                begin
                    out_next    = res_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            second_reg <= second_next;
        end
    end

    // The output register changes only in S_OUT once it is free, so a waiting
    // result is held while the next request is worked on.
    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        p1_reg     <= p1_next;
        mag_reg    <= mag_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        gx_reg     <= gx_next;
        gy_reg     <= gy_next;
        fa_neg_reg <= fa_neg_next;
        fa_mag_reg <= fa_mag_next;
        fa_den_reg <= fa_den_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = ovalid_reg;
    assign rsp.data  = out_reg;
endmodule

// ----- test/rational_arithmetic_unit_tb.sv -----
// Self-checking testbench of the rational arithmetic unit with its own fraction calculator.
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    class rau_scoreboard;
        rau_rsp_t expected_q[$];
        int       mismatches;

        function automatic bit [63:0] euclid_gcd(bit [63:0] x, bit [63:0] y);
            bit [63:0] t;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        // Splits num/den into sign, magnitude and denominator in lowest terms.
        function automatic void lowest_terms(longint num, bit [63:0] den, output bit neg,
                                             output bit [63:0] mag, output bit [63:0] dn);
            bit [63:0] g;
            neg = num < 0;
            mag = neg ? 64'(-num) : 64'(num);
            if (mag == 0)
            begin
                neg = 1'b0;
                dn = 64'd1;
            end
            else
            begin
                g = euclid_gcd(mag, den);
                mag = mag / g;
                dn = den / g;
            end
        endfunction

        function automatic rau_rsp_t fraction_result(rau_req_t r);
            rau_rsp_t  res;
            longint    an, bn, ad, bd, num;
            bit [63:0] den, mag, dn, mag_b, dn_b;
            bit        neg, neg_b;
            bit [63:0] lim;
            lim = 64'h7FFF_FFFF;
            res = '0;
            res.result_denominator = 31'd1;
            an = longint'(signed'(r.a_numerator));
            bn = longint'(signed'(r.b_numerator));
            ad = longint'({33'd0, r.a_denominator});
            bd = longint'({33'd0, r.b_denominator});
            if (r.opcode > OP_EQU)
                return res;
            if (ad == 0 || (r.opcode != OP_NEG && r.opcode != OP_RED && bd == 0))
            begin
                res.error_flag = 1'b1;
                return res;
            end
            case (r.opcode)
                OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
                OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
                OP_MUL: begin num = an * bn; den = ad * bd; end
                OP_NEG: begin num = -an; den = ad; end
                OP_RED: begin num = an; den = ad; end
                default:
                begin
                    lowest_terms(an, ad, neg, mag, dn);
                    lowest_terms(bn, bd, neg_b, mag_b, dn_b);
                    res.equal_flag = (neg == neg_b) && (mag == mag_b) && (dn == dn_b);
                    return res;
                end
            endcase
            lowest_terms(num, den, neg, mag, dn);
            if (dn > lim || mag > (neg ? lim + 1 : lim))
            begin
                res.overflow_flag = 1'b1;
                return res;
            end
            num = neg ? -longint'(mag) : longint'(mag);
            res.result_numerator = num[31:0];
            res.result_denominator = dn[30:0];
            return res;
        endfunction

        function void note_request(rau_req_t r);
            expected_q.push_back(fraction_result(r));
        endfunction

        function void check_result(rau_rsp_t got);
            rau_rsp_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got.result_numerator !== want.result_numerator
                || got.result_denominator !== want.result_denominator
                || got.equal_flag !== want.equal_flag
                || got.overflow_flag !== want.overflow_flag
                || got.error_flag !== want.error_flag)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected %0d/%0d eq=%b ovf=%b err=%b, ",
                              "got %0d/%0d eq=%b ovf=%b err=%b"},
                             want.result_numerator, want.result_denominator, want.equal_flag,
                             want.overflow_flag, want.error_flag, got.result_numerator,
                             got.result_denominator, got.equal_flag, got.overflow_flag,
                             got.error_flag);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    rau_scoreboard sb;

    rau_req_if req_if ();
    rau_rsp_if rsp_if ();

    rational_arithmetic_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #500ms;
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.data);
    end

    task automatic send_request(logic [2:0] op, logic signed [31:0] an, logic [30:0] ad,
                                logic signed [31:0] bn, logic [30:0] bd);
        rau_req_t r;
        r = '{op, an, ad, bn, bd};
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= r;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(r);
    endtask

    function automatic logic signed [31:0] rand_numerator();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return $signed($urandom_range(0, 200000)) - 100000;
            default: return $signed($urandom_range(0, 60)) - 30;
        endcase
    endfunction

    function automatic logic [30:0] rand_denominator();
        case ($urandom_range(0, 31))
            0: return 31'd0;
            1, 2, 3, 4, 5, 6: return 31'($urandom());
            7, 8, 9, 10, 11: return 31'($urandom_range(1, 100000));
            default: return 31'($urandom_range(1, 60));
        endcase
    endfunction

    task automatic send_random();
        logic [2:0]         op;
        logic signed [31:0] an, bn;
        logic [30:0]        ad, bd;
        int                 k;
        op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        an = rand_numerator();
        bn = rand_numerator();
        ad = rand_denominator();
        bd = rand_denominator();
        // Scaled copies make the equality test come out true often enough.
        if (op == OP_EQU && $urandom_range(0, 1))
        begin
            k = $urandom_range(1, 9);
            an = $signed($urandom_range(0, 2000)) - 1000;
            ad = 31'($urandom_range(1, 1000));
            bn = an * k;
            bd = 31'(ad * k);
        end
        send_request(op, an, ad, bn, bd);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        send_idle_pct = 36;
        recv_idle_pct = 69;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);
        send_request(OP_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2);
        send_request(OP_MUL, -32'sd4, 31'd6, 32'sd3, 31'd8);
        send_request(OP_NEG, 32'sd6, 31'd4, 32'sd0, 31'd0);
        send_request(OP_RED, -32'sd12, 31'd18, 32'sd5, 31'd0);
        send_request(OP_EQU, 32'sd1, 31'd2, 32'sd2, 31'd4);
        send_request(OP_EQU, 32'sd0, 31'd5, 32'sd0, 31'd3);
        send_request(OP_EQU, 32'sd1, 31'd2, -32'sd1, 31'd2);
        send_request(OP_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1);
        send_request(OP_MUL, 32'sd1, 31'd1, 32'sd1, 31'd0);
        send_request(OP_EQU, 32'sd1, 31'd1, 32'sd1, 31'd0);
        send_request(OP_NEG, 32'sd1, 31'd0, 32'sd1, 31'd1);
        send_request(3'd6, 32'sd7, 31'd3, 32'sd1, 31'd1);
        send_request(3'd7, -32'sd1, 31'h7FFF_FFFF, 32'sd1, 31'd0);
        send_request(OP_ADD, 32'sh7FFF_FFFF, 31'd1, 32'sd1, 31'd1);
        send_request(OP_SUB, 32'sh8000_0000, 31'd1, 32'sd1, 31'd1);
        send_request(OP_NEG, 32'sh8000_0000, 31'd1, 32'sd0, 31'd1);
        send_request(OP_RED, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sd0, 31'd1);
        send_request(OP_MUL, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
        send_request(OP_MUL, 32'sd1, 31'h7FFF_FFFF, 32'sd1, 31'd2);
        send_request(OP_ADD, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, -32'sd1, 31'h7FFF_FFFE);
        send_request(OP_SUB, 32'sd0, 31'd9, 32'sd0, 31'd7);
        send_request(OP_RED, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, -32'sd1, 31'h5555_5555);

        repeat (310) send_random();
        send_idle_pct = 69;
        recv_idle_pct = 36;
        repeat (310) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (310) send_random();
        req_if.valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
